// ===== sv/tmn_pkg.sv =====
// Shared types, codes and defaults of the token mutex node.
`default_nettype none

package tmn_pkg;

    localparam int MAX_NODES_DEF = 32;
    localparam int SEQ_BITS_DEF  = 16;
    localparam int CFG_DATA_W    = 6;

    // input function codes
    localparam logic [1:0] FUNC_REQUEST = 2'd0;
    localparam logic [1:0] FUNC_TOKEN   = 2'd1;
    localparam logic [1:0] FUNC_WANT    = 2'd2;
    localparam logic [1:0] FUNC_EXIT    = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_BCAST = 2'd1;
    localparam logic [1:0] KIND_TOKEN = 2'd2;
    localparam logic [1:0] KIND_GRANT = 2'd3;

    // protocol modes
    localparam logic [1:0] MODE_RELEASED  = 2'd0;
    localparam logic [1:0] MODE_REQUESTED = 2'd1;
    localparam logic [1:0] MODE_GRANTED   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_MY_ID        = 2'd0;
    localparam logic [1:0] CFG_NODE_COUNT   = 2'd1;
    localparam logic [1:0] CFG_STARTS_TOKEN = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [4:0]  peer;
        logic [15:0] seq;
        logic [4:0]  tok_index;
        logic [15:0] tok_served;
        logic [4:0]  tok_queue_entry;
        logic [5:0]  tok_queue_len;
        logic        tok_last;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  dest;
        logic [15:0] out_seq;
        logic [4:0]  out_index;
        logic [15:0] out_served;
        logic [4:0]  out_queue_entry;
        logic [5:0]  out_queue_len;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic req;
        logic srv;
        logic queue;
    } store_we_t;

endpackage

`default_nettype wire

// ===== sv/token_mutex_node_core.sv =====
// Token mutual exclusion node: sequencer, shared compare and output register.
// Throughput: one item at a time; the single-port number tables and the queue table set the pace.
// Reset: synchronous, active low; number tables read zero at once through per-entry valid bits.
`default_nettype none

module token_mutex_node_core
    import tmn_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int SEQ_BITS  = SEQ_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int QW = (NW > 5) ? NW : 5;
    localparam int QN = 1 << QW;

    typedef enum logic [19:0] {
        ST_IDLE     = 20'b1 << 0,
        ST_REDUCE   = 20'b1 << 1,
        ST_REQ_RD   = 20'b1 << 2,
        ST_REQ_USE  = 20'b1 << 3,
        ST_TOK_WR   = 20'b1 << 4,
        ST_WANT_RD  = 20'b1 << 5,
        ST_WANT_USE = 20'b1 << 6,
        ST_EXIT_RD  = 20'b1 << 7,
        ST_EXIT_WR  = 20'b1 << 8,
        ST_MAP_RD   = 20'b1 << 9,
        ST_MAP_USE  = 20'b1 << 10,
        ST_SCAN_RD  = 20'b1 << 11,
        ST_SCAN_USE = 20'b1 << 12,
        ST_HEAD_RD  = 20'b1 << 13,
        ST_HEAD_USE = 20'b1 << 14,
        ST_SHIFT_RD = 20'b1 << 15,
        ST_SHIFT_WR = 20'b1 << 16,
        ST_SEND_RD  = 20'b1 << 17,
        ST_SEND_OUT = 20'b1 << 18,
        ST_EMIT     = 20'b1 << 19
    } state_t;

    state_t        state_reg, state_next;
    in_item_t      in_reg, in_next;
    logic [4:0]    red_reg, red_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] qlen_reg, qlen_next;
    logic [QN-1:0] bitmap_reg, bitmap_next;
    logic [4:0]    dest_reg, dest_next;
    logic [1:0]    emit_kind_reg, emit_kind_next;
    logic [15:0]   emit_seq_reg, emit_seq_next;
    logic [1:0]    mode_reg, mode_next;
    logic          holds_reg, holds_next;
    logic [4:0]    my_id_reg, my_id_next;
    logic [5:0]    node_count_reg, node_count_next;
    logic          starts_reg, starts_next;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_reg, out_next;

    store_we_t         we;
    logic [NW-1:0]     num_addr;
    logic [SEQ_BITS-1:0] req_wdata, srv_wdata, req_rdata, srv_rdata;
    logic [NW-1:0]     q_waddr, q_raddr;
    logic [QW-1:0]     q_wdata, q_rdata;

    logic [CW-1:0]       n_eff;
    logic [CW-1:0]       cnt_inc;
    logic [NW-1:0]       cnt_idx;
    logic [NW-1:0]       idx_red;
    logic [SEQ_BITS-1:0] s_in;
    logic [SEQ_BITS-1:0] new_req;
    logic [SEQ_BITS-1:0] cmp_a;
    logic [SEQ_BITS:0]   srv_inc;
    logic                outstanding;
    logic                out_free;
    logic                out_load;
    out_item_t           out_word;

    tmn_store #(
        .MAX_NODES (MAX_NODES),
        .SEQ_BITS  (SEQ_BITS),
        .QW        (QW)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .we        (we),
        .num_addr  (num_addr),
        .req_wdata (req_wdata),
        .srv_wdata (srv_wdata),
        .q_waddr   (q_waddr),
        .q_raddr   (q_raddr),
        .q_wdata   (q_wdata),
        .req_rdata (req_rdata),
        .srv_rdata (srv_rdata),
        .q_rdata   (q_rdata)
    );

    // clamp the node count to 1..MAX_NODES
    always_comb begin
        if (int'(node_count_reg) > MAX_NODES) begin
            n_eff = CW'(MAX_NODES);
        end else if (node_count_reg == '0) begin
            n_eff = CW'(1);
        end else begin
            n_eff = CW'(node_count_reg);
        end
    end

    assign cnt_inc  = cnt_reg + CW'(1);
    assign cnt_idx  = cnt_reg[NW-1:0];
    assign idx_red  = NW'(red_reg);
    assign s_in     = SEQ_BITS'(in_reg.seq);
    assign new_req  = (s_in > req_rdata) ? s_in : req_rdata;

    // shared compare: request number equals served number plus one
    assign cmp_a       = (state_reg == ST_REQ_USE) ? new_req : req_rdata;
    assign srv_inc     = {1'b0, srv_rdata} + {{SEQ_BITS{1'b0}}, 1'b1};
    assign outstanding = ({1'b0, cmp_a} == srv_inc);

    assign out_free  = !out_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_comb begin
        state_next      = state_reg;
        in_next         = in_reg;
        red_next        = red_reg;
        cnt_next        = cnt_reg;
        qlen_next       = qlen_reg;
        bitmap_next     = bitmap_reg;
        dest_next       = dest_reg;
        emit_kind_next  = emit_kind_reg;
        emit_seq_next   = emit_seq_reg;
        mode_next       = mode_reg;
        holds_next      = holds_reg;
        my_id_next      = my_id_reg;
        node_count_next = node_count_reg;
        starts_next     = starts_reg;
        we              = '0;
        num_addr        = '0;
        req_wdata       = '0;
        srv_wdata       = '0;
        q_waddr         = '0;
        q_raddr         = '0;
        q_wdata         = '0;
        out_load        = 1'b0;
        out_word        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next        = s_data;
                    red_next       = (s_data.func == FUNC_TOKEN) ? s_data.tok_index : my_id_reg;
                    emit_kind_next = KIND_NONE;
                    emit_seq_next  = '0;
                    state_next     = ST_EMIT;
                    unique case (s_data.func)
                        FUNC_REQUEST: begin
                            if (!(int'(s_data.peer) >= int'(n_eff)
                                  || s_data.peer == my_id_reg)) begin
                                state_next = ST_REQ_RD;
                            end
                        end
                        FUNC_TOKEN: begin
                            if (!holds_reg) begin
                                state_next = ST_REDUCE;
                            end
                        end
                        FUNC_WANT: begin
                            if (mode_reg == MODE_RELEASED) begin
                                if (holds_reg) begin
                                    mode_next      = MODE_GRANTED;
                                    emit_kind_next = KIND_GRANT;
                                end else begin
                                    state_next = ST_REDUCE;
                                end
                            end
                        end
                        FUNC_EXIT: begin
                            if (mode_reg == MODE_GRANTED && holds_reg) begin
                                state_next = ST_REDUCE;
                            end
                        end
                        default: begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_REDUCE: begin
                // bring the node index below MAX_NODES one subtract a cycle
                if (int'(red_reg) >= MAX_NODES) begin
                    red_next = red_reg - 5'(MAX_NODES);
                end else begin
                    unique case (in_reg.func)
                        FUNC_TOKEN: state_next = ST_TOK_WR;
                        FUNC_WANT:  state_next = ST_WANT_RD;
                        FUNC_EXIT:  state_next = ST_EXIT_RD;
                        default:    state_next = ST_EMIT;
                    endcase
                end
            end
            ST_REQ_RD: begin
                num_addr   = NW'(in_reg.peer);
                state_next = ST_REQ_USE;
            end
            ST_REQ_USE: begin
                num_addr   = NW'(in_reg.peer);
                we.req     = 1'b1;
                req_wdata  = new_req;
                if (mode_reg == MODE_RELEASED && holds_reg && outstanding) begin
                    dest_next  = in_reg.peer;
                    cnt_next   = '0;
                    state_next = ST_SEND_RD;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_TOK_WR: begin
                num_addr  = idx_red;
                we.srv    = 1'b1;
                srv_wdata = SEQ_BITS'(in_reg.tok_served);
                we.queue  = 1'b1;
                q_waddr   = idx_red;
                q_wdata   = QW'(in_reg.tok_queue_entry);
                if (int'(in_reg.tok_queue_len) > MAX_NODES) begin
                    qlen_next = CW'(MAX_NODES);
                end else begin
                    qlen_next = CW'(in_reg.tok_queue_len);
                end
                if (in_reg.tok_last) begin
                    holds_next = 1'b1;
                    if (mode_reg == MODE_REQUESTED) begin
                        mode_next      = MODE_GRANTED;
                        emit_kind_next = KIND_GRANT;
                    end
                end
                state_next = ST_EMIT;
            end
            ST_WANT_RD: begin
                num_addr   = idx_red;
                state_next = ST_WANT_USE;
            end
            ST_WANT_USE: begin
                num_addr  = idx_red;
                we.req    = 1'b1;
                // saturate at the top value
                req_wdata = (&req_rdata) ? req_rdata : req_rdata + SEQ_BITS'(1);
                mode_next      = MODE_REQUESTED;
                emit_kind_next = KIND_BCAST;
                emit_seq_next  = 16'(req_wdata);
                state_next     = ST_EMIT;
            end
            ST_EXIT_RD: begin
                num_addr   = idx_red;
                state_next = ST_EXIT_WR;
            end
            ST_EXIT_WR: begin
                num_addr    = idx_red;
                we.srv      = 1'b1;
                srv_wdata   = req_rdata;
                bitmap_next = '0;
                cnt_next    = '0;
                state_next  = ST_MAP_RD;
            end
            ST_MAP_RD: begin
                // mark every value already in the queue
                if (cnt_reg == qlen_reg) begin
                    cnt_next   = '0;
                    state_next = ST_SCAN_RD;
                end else begin
                    q_raddr    = cnt_idx;
                    state_next = ST_MAP_USE;
                end
            end
            ST_MAP_USE: begin
                bitmap_next[q_rdata] = 1'b1;
                cnt_next             = cnt_inc;
                state_next           = ST_MAP_RD;
            end
            ST_SCAN_RD: begin
                if (cnt_reg == n_eff) begin
                    mode_next = MODE_RELEASED;
                    if (qlen_reg != '0) begin
                        state_next = ST_HEAD_RD;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end else if (int'(cnt_reg) == int'(my_id_reg)) begin
                    cnt_next = cnt_inc;
                end else begin
                    num_addr   = cnt_idx;
                    state_next = ST_SCAN_USE;
                end
            end
            ST_SCAN_USE: begin
                num_addr = cnt_idx;
                if (outstanding && !bitmap_reg[QW'(cnt_idx)]
                    && int'(qlen_reg) < MAX_NODES) begin
                    we.queue                  = 1'b1;
                    q_waddr                   = qlen_reg[NW-1:0];
                    q_wdata                   = QW'(cnt_idx);
                    qlen_next                 = qlen_reg + CW'(1);
                    bitmap_next[QW'(cnt_idx)] = 1'b1;
                end
                cnt_next   = cnt_inc;
                state_next = ST_SCAN_RD;
            end
            ST_HEAD_RD: begin
                q_raddr    = '0;
                state_next = ST_HEAD_USE;
            end
            ST_HEAD_USE: begin
                dest_next  = q_rdata[4:0];
                cnt_next   = '0;
                state_next = ST_SHIFT_RD;
            end
            ST_SHIFT_RD: begin
                // pop the head: move every entry down by one
                if (int'(cnt_reg) + 1 >= int'(qlen_reg)) begin
                    qlen_next  = qlen_reg - CW'(1);
                    cnt_next   = '0;
                    state_next = ST_SEND_RD;
                end else begin
                    q_raddr    = cnt_inc[NW-1:0];
                    state_next = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR: begin
                we.queue   = 1'b1;
                q_waddr    = cnt_idx;
                q_wdata    = q_rdata;
                cnt_next   = cnt_inc;
                state_next = ST_SHIFT_RD;
            end
            ST_SEND_RD: begin
                num_addr   = cnt_idx;
                q_raddr    = cnt_idx;
                state_next = ST_SEND_OUT;
            end
            ST_SEND_OUT: begin
                // hold the read address so the data stays while stalled
                num_addr                 = cnt_idx;
                q_raddr                  = cnt_idx;
                out_word.kind            = KIND_TOKEN;
                out_word.dest            = dest_reg;
                out_word.out_index       = 5'(cnt_reg);
                out_word.out_served      = 16'(srv_rdata);
                out_word.out_queue_entry = (cnt_reg < qlen_reg) ? q_rdata[4:0] : 5'd0;
                out_word.out_queue_len   = 6'(qlen_reg);
                out_word.last            = (cnt_inc == n_eff);
                if (out_free) begin
                    out_load = 1'b1;
                    if (cnt_inc == n_eff) begin
                        holds_next = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        cnt_next   = cnt_inc;
                        state_next = ST_SEND_RD;
                    end
                end
            end
            ST_EMIT: begin
                out_word.kind    = emit_kind_reg;
                out_word.out_seq = emit_seq_reg;
                out_word.last    = 1'b1;
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MY_ID:      my_id_next      = cfg_data[4:0];
                CFG_NODE_COUNT: node_count_next = cfg_data;
                CFG_STARTS_TOKEN: begin
                    starts_next = cfg_data[0];
                    holds_next  = cfg_data[0];
                end
                default: begin
                    my_id_next = my_id_reg;
                end
            endcase
        end
    end

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_next       = out_word;
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            qlen_reg       <= '0;
            mode_reg       <= MODE_RELEASED;
            holds_reg      <= 1'b0;
            my_id_reg      <= '0;
            node_count_reg <= 6'd1;
            starts_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            qlen_reg       <= qlen_next;
            mode_reg       <= mode_next;
            holds_reg      <= holds_next;
            my_id_reg      <= my_id_next;
            node_count_reg <= node_count_next;
            starts_reg     <= starts_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg        <= in_next;
        red_reg       <= red_next;
        cnt_reg       <= cnt_next;
        bitmap_reg    <= bitmap_next;
        dest_reg      <= dest_next;
        emit_kind_reg <= emit_kind_next;
        emit_seq_reg  <= emit_seq_next;
        out_reg       <= out_next;
    end

`ifndef SYNTHESIS
    a_qlen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(qlen_reg) <= MAX_NODES)
        else $error("wait queue length beyond MAX_NODES");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is still in work");

    a_token_released: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SEND_OUT && out_free && cnt_inc == n_eff |=> !holds_reg)
        else $error("token still held after its last word went out");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |=> !m_valid
            || $past(state_reg == ST_EMIT || state_reg == ST_SEND_OUT))
        else $error("result loaded outside an output state");
`endif

endmodule

`default_nettype wire

// ===== sv/tmn_store.sv =====
// Request, served and wait queue tables with registered read ports.
`default_nettype none

module tmn_store
    import tmn_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int SEQ_BITS  = SEQ_BITS_DEF,
    parameter int QW        = 5
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire store_we_t                    we,
    input  wire logic [$clog2(MAX_NODES)-1:0] num_addr,
    input  wire logic [SEQ_BITS-1:0]          req_wdata,
    input  wire logic [SEQ_BITS-1:0]          srv_wdata,
    input  wire logic [$clog2(MAX_NODES)-1:0] q_waddr,
    input  wire logic [$clog2(MAX_NODES)-1:0] q_raddr,
    input  wire logic [QW-1:0]                q_wdata,
    output logic      [SEQ_BITS-1:0]          req_rdata,
    output logic      [SEQ_BITS-1:0]          srv_rdata,
    output logic      [QW-1:0]                q_rdata
);

    logic [SEQ_BITS-1:0]  req_mem [MAX_NODES];
    logic [SEQ_BITS-1:0]  srv_mem [MAX_NODES];
    logic [QW-1:0]        q_mem   [MAX_NODES];

    logic [MAX_NODES-1:0] req_vld_reg;
    logic [MAX_NODES-1:0] srv_vld_reg;
    logic                 req_rv_reg;
    logic                 srv_rv_reg;
    logic [SEQ_BITS-1:0]  req_rd_reg;
    logic [SEQ_BITS-1:0]  srv_rd_reg;
    logic [QW-1:0]        q_rd_reg;

    // number tables: an entry never written reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_vld_reg <= '0;
            srv_vld_reg <= '0;
            req_rv_reg  <= 1'b0;
            srv_rv_reg  <= 1'b0;
        end else begin
            if (we.req) begin
                req_vld_reg[num_addr] <= 1'b1;
            end
            if (we.srv) begin
                srv_vld_reg[num_addr] <= 1'b1;
            end
            req_rv_reg <= req_vld_reg[num_addr];
            srv_rv_reg <= srv_vld_reg[num_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (we.req) begin
            req_mem[num_addr] <= req_wdata;
        end
        req_rd_reg <= req_mem[num_addr];
    end

    always_ff @(posedge aclk) begin
        if (we.srv) begin
            srv_mem[num_addr] <= srv_wdata;
        end
        srv_rd_reg <= srv_mem[num_addr];
    end

    always_ff @(posedge aclk) begin
        if (we.queue) begin
            q_mem[q_waddr] <= q_wdata;
        end
        q_rd_reg <= q_mem[q_raddr];
    end

    assign req_rdata = req_rv_reg ? req_rd_reg : '0;
    assign srv_rdata = srv_rv_reg ? srv_rd_reg : '0;
    assign q_rdata   = q_rd_reg;

endmodule

`default_nettype wire
